@@ hw/rtl/ptts_pkg.sv @@
// Shared types and constants for the periodic task tick scheduler.
// Used by ptts_ctrl, ptts_datapath and periodic_task_tick_scheduler_top.
`timescale 1ns / 1ps

package ptts_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_ATTACH  = 2'd1;
    localparam logic [1:0] KIND_SERVICE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DELAY = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;

    localparam logic [11:0] TPS_RESET = 12'd1000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] interval_ticks;
        logic [15:0] first_delay;
    } item_t;

    typedef struct packed {
        logic [15:0] pending_mask;
        logic [31:0] seconds;
        logic [11:0] subsecond;
        logic [4:0]  slot_count;
        logic [1:0]  status;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic issue;
        logic load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rd_more;
        logic upd_busy;
        logic out_free;
    } dp_status_t;

endpackage

@@ hw/rtl/periodic_task_tick_scheduler_top.sv @@
// Top level of the periodic task tick scheduler.
// Depends on ptts_pkg, ptts_ctrl and ptts_datapath.
//
//  channel   signals                                    payload
//  item      item_valid / item_ready                    item (ptts_pkg::item_t)
//  result    result_valid / result_ready                result (ptts_pkg::result_t)
//  config    cfg_wr_en                                  cfg_wr_data (ticks per second)
//
// A tick walks the active slots after acceptance: the slot walk reads one slot memory word
// per cycle into a read data register and writes back each word whose countdown was not zero.
// Attach, service and unused kinds skip the walk. One transaction is in work at a time.
// Reset is asynchronous; slot memory contents are not cleared and need no clearing pass.
// A stalled result holds in the output register while the next item is accepted; a second
// result waits, with the controller in ST_DONE, until the first one is taken.
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ptts_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output ptts_pkg::result_t result,
    input  logic              cfg_wr_en,
    input  logic [11:0]       cfg_wr_data
);
    import ptts_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    ptts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .item_ready (item_ready),
        .status     (dp_status),
        .cmd        (cmd)
    );

    ptts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .status       (dp_status),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ hw/rtl/ptts_datapath.sv @@
// Datapath: slot memory, pending bits, tick and second counters, result register.
// Depends on ptts_pkg; driven by ptts_ctrl through ctrl_cmd_t.
`timescale 1ns / 1ps

module ptts_datapath #(
    parameter int MAX_TASKS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptts_pkg::item_t      item,
    input  logic                 cfg_wr_en,
    input  logic [11:0]          cfg_wr_data,
    input  ptts_pkg::ctrl_cmd_t  cmd,
    output ptts_pkg::dp_status_t status,
    input  logic                 result_ready,
    output logic                 result_valid,
    output ptts_pkg::result_t    result
);
    import ptts_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    // Each word holds the reload interval in the upper half and the countdown below.
    logic [31:0] slot_mem [MAX_TASKS];
    logic [31:0] rd_data_reg;

    logic [11:0]          tps_reg;
    logic [11:0]          tick_reg, tick_next;
    logic [31:0]          sec_reg, sec_next;
    logic [CNT_W-1:0]     active_reg, active_next;
    logic [MAX_TASKS-1:0] pending_reg, pending_next;
    logic [1:0]           status_reg, status_next;
    logic [1:0]           kind_reg, kind_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 upd_vld_reg;
    logic [IDX_W-1:0]     upd_idx_reg, upd_idx_next;
    result_t              result_reg, result_next;
    logic                 result_valid_reg, result_valid_next;

    logic [12:0] tick_inc;
    logic        tick_wrap;
    logic        full;
    logic        attach_wr;
    logic [15:0] cnt, dec;
    logic        upd_wr, fire;
    logic        mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0] mem_wdata;

    assign tick_inc  = {1'b0, tick_reg} + 13'd1;
    assign tick_wrap = tick_inc >= {1'b0, tps_reg};
    assign full      = active_reg == CNT_W'(MAX_TASKS);
    assign attach_wr = cmd.accept && (item.kind == KIND_ATTACH) && !full;

    assign cnt    = rd_data_reg[15:0];
    assign dec    = cnt - 16'd1;
    assign upd_wr = upd_vld_reg && (cnt != 16'd0);
    assign fire   = upd_wr && (dec == 16'd0);

    assign mem_we    = attach_wr || upd_wr;
    assign mem_waddr = attach_wr ? active_reg[IDX_W-1:0] : upd_idx_reg;
    assign mem_wdata = attach_wr ? {item.interval_ticks, item.first_delay}
                                 : {rd_data_reg[31:16], fire ? rd_data_reg[31:16] : dec};

    assign status.rd_more  = rd_idx_reg < active_reg;
    assign status.upd_busy = upd_vld_reg;
    assign status.out_free = !result_valid_reg || result_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        tick_next         = tick_reg;
        sec_next          = sec_reg;
        active_next       = active_reg;
        pending_next      = pending_reg;
        status_next       = status_reg;
        kind_next         = kind_reg;
        rd_idx_next       = rd_idx_reg;
        upd_idx_next      = upd_idx_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (cmd.accept)
        begin
            kind_next   = item.kind;
            rd_idx_next = '0;
            status_next = STATUS_OK;
            if (item.kind == KIND_TICK)
            begin
                if (tick_wrap)
                begin
                    tick_next = '0;
                    sec_next  = sec_reg + 32'd1;
                end
                else
                begin
                    tick_next = tick_inc[11:0];
                end
            end
            else if (item.kind == KIND_ATTACH)
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    pending_next[active_reg[IDX_W-1:0]] = 1'b0;
                    active_next = active_reg + CNT_W'(1);
                    status_next = (item.first_delay == 16'd0) ? STATUS_ZERO_DELAY
                                                              : STATUS_OK;
                end
            end
        end

        if (cmd.issue)
        begin
            rd_idx_next  = rd_idx_reg + CNT_W'(1);
            upd_idx_next = rd_idx_reg[IDX_W-1:0];
        end

        if (fire)
        begin
            pending_next[upd_idx_reg] = 1'b1;
        end

        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            result_next.pending_mask = 16'(pending_reg);
            result_next.seconds      = sec_reg;
            result_next.subsecond    = tick_reg;
            result_next.slot_count   = 5'(active_reg);
            result_next.status       = status_reg;
            result_valid_next        = 1'b1;
            // A service reports the pending bits and then clears them.
            if (kind_reg == KIND_SERVICE)
            begin
                pending_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg          <= TPS_RESET;
            tick_reg         <= '0;
            sec_reg          <= '0;
            active_reg       <= '0;
            pending_reg      <= '0;
            status_reg       <= STATUS_OK;
            kind_reg         <= KIND_TICK;
            rd_idx_reg       <= '0;
            upd_vld_reg      <= 1'b0;
            upd_idx_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tps_reg <= cfg_wr_data;
            end
            tick_reg         <= tick_next;
            sec_reg          <= sec_next;
            active_reg       <= active_next;
            pending_reg      <= pending_next;
            status_reg       <= status_next;
            kind_reg         <= kind_next;
            rd_idx_reg       <= rd_idx_next;
            upd_vld_reg      <= cmd.issue;
            upd_idx_reg      <= upd_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= slot_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    a_active_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= CNT_W'(MAX_TASKS))
        else $error("active slot count exceeds table size");

    a_unattached_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg >> active_reg) == '0)
        else $error("pending bit set on an unattached slot");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(attach_wr && upd_wr))
        else $error("attach and slot update write in the same cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (status.out_free && !upd_vld_reg))
        else $error("result loaded while output busy or walk unfinished");

endmodule

@@ hw/rtl/ptts_ctrl.sv @@
// Controller state machine: accepts items, sequences the slot walk, loads results.
// Depends on ptts_pkg; drives ptts_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module ptts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [1:0]           item_kind,
    output logic                 item_ready,
    input  ptts_pkg::dp_status_t status,
    output ptts_pkg::ctrl_cmd_t  cmd
);
    import ptts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    assign item_ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (item_kind == KIND_TICK) ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK:
            begin
                cmd.issue = status.rd_more;
                if (!status.rd_more && !status.upd_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_walk_exit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && state_next == ST_DONE) |-> !cmd.issue)
        else $error("walk left while slot reads remain");

    a_tick_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && item_kind == KIND_TICK) |=> state_reg == ST_WALK)
        else $error("tick accepted without a slot walk");

    a_issue_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (state_reg == ST_WALK && status.rd_more))
        else $error("slot read issued outside the walk");

endmodule

@@ sim/tb_periodic_task_tick_scheduler_top.sv @@
// Self-checking testbench for periodic_task_tick_scheduler_top.
// Depends on ptts_pkg and the scheduler RTL; predicts every result with a behavioral
// model of the slot table and timekeeping, and compares it against the result channel.
`timescale 1ns / 1ps

module tb_periodic_task_tick_scheduler_top;

    import ptts_pkg::*;

    localparam int          NUM_SLOTS   = 16;
    localparam logic [1:0]  KIND_SPARE  = 2'd3;
    localparam int          PHASE_ITEMS = 225;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    item_t       item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        cfg_wr_en = 1'b0;
    logic [11:0] cfg_wr_data = '0;

    // Stimulus backlog and the results it is expected to produce.
    item_t   item_backlog[$];
    result_t report_q[$];

    int unsigned sent_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned fail_count = 0;
    logic        calm = 1'b0;

    // Shadow copy of the scheduler state.
    logic [15:0] m_countdown[NUM_SLOTS];
    logic [15:0] m_reload[NUM_SLOTS];
    logic [15:0] m_pending;
    int          m_slots;
    logic [11:0] m_ticks;
    logic [31:0] m_seconds;
    logic [11:0] m_tps;

    periodic_task_tick_scheduler_top #(
        .MAX_TASKS(NUM_SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #10 clk = ~clk;

    function automatic void reset_schedule();
        int i;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            m_countdown[i] = 16'hFFFF;
            m_reload[i]    = 16'hFFFF;
        end
        m_pending = '0;
        m_slots   = 0;
        m_ticks   = '0;
        m_seconds = '0;
        m_tps     = TPS_RESET;
    endfunction

    // Applies one accepted transaction to the shadow state and returns its report.
    function automatic result_t schedule_step(input item_t it);
        result_t     r;
        logic [12:0] nxt;
        logic [15:0] mask;
        int          i;
        r.status = STATUS_OK;
        case (it.kind)
            KIND_TICK:
            begin
                nxt = {1'b0, m_ticks} + 13'd1;
                if (nxt >= {1'b0, m_tps})
                begin
                    nxt = '0;
                    m_seconds = m_seconds + 32'd1;
                end
                m_ticks = nxt[11:0];
                for (i = 0; i < m_slots && i < NUM_SLOTS; i++)
                begin
                    if (m_countdown[i] != 16'd0)
                    begin
                        m_countdown[i] = m_countdown[i] - 16'd1;
                        if (m_countdown[i] == 16'd0)
                        begin
                            m_countdown[i] = m_reload[i];
                            m_pending[i] = 1'b1;
                        end
                    end
                end
                mask = m_pending;
            end
            KIND_ATTACH:
            begin
                if (m_slots >= NUM_SLOTS)
                    r.status = STATUS_FULL;
                else
                begin
                    m_countdown[m_slots] = it.first_delay;
                    m_reload[m_slots]    = it.interval_ticks;
                    m_pending[m_slots]   = 1'b0;
                    m_slots = m_slots + 1;
                    if (it.first_delay == 16'd0)
                        r.status = STATUS_ZERO_DELAY;
                end
                mask = m_pending;
            end
            KIND_SERVICE:
            begin
                mask = m_pending;
                m_pending = '0;
            end
            default:
                mask = m_pending;
        endcase
        r.pending_mask = mask;
        r.seconds      = m_seconds;
        r.subsecond    = m_ticks;
        r.slot_count   = m_slots[4:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Item driver: a new transaction is presented only once the previous one was taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (item_valid && accepted_cnt != sent_cnt)
        begin
            // Hold the current transaction until it is accepted.
        end
        else if (item_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 9))
        begin
            item       <= item_backlog.pop_front();
            item_valid <= 1'b1;
            sent_cnt   <= sent_cnt + 1;
        end
        else
            item_valid <= 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= calm || ($urandom_range(0, 99) >= 9);
    end

    // Monitor: results are checked before the transaction accepted at the same edge
    // is predicted, since a result always belongs to an earlier transaction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $error("unexpected result: pending_mask %0h", result.pending_mask);
                    fail_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("pending_mask", 32'(want.pending_mask),
                                32'(result.pending_mask));
                    check_field("seconds", want.seconds, result.seconds);
                    check_field("subsecond", 32'(want.subsecond), 32'(result.subsecond));
                    check_field("slot_count", 32'(want.slot_count),
                                32'(result.slot_count));
                    check_field("status", 32'(want.status), 32'(result.status));
                end
            end
            if (item_valid && item_ready)
            begin
                report_q.push_back(schedule_step(item));
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    task automatic queue_item(input logic [1:0] kind, input logic [15:0] interval,
                              input logic [15:0] delay);
        item_t it;
        it.kind           = kind;
        it.interval_ticks = interval;
        it.first_delay    = delay;
        item_backlog.push_back(it);
    endtask

    // Mostly ticks and services so that slots keep firing; attaches favor short periods.
    task automatic queue_random_item();
        int unsigned pick;
        logic [15:0] interval;
        logic [15:0] delay;
        pick     = $urandom_range(0, 99);
        interval = 16'($urandom_range(0, 65535));
        delay    = 16'($urandom_range(0, 65535));
        if (pick < 62)
            queue_item(KIND_TICK, interval, delay);
        else if (pick < 82)
            queue_item(KIND_SERVICE, interval, delay);
        else if (pick < 96)
        begin
            if ($urandom_range(0, 9) < 8)
                interval = 16'($urandom_range(0, 24));
            if ($urandom_range(0, 9) < 7)
                delay = 16'($urandom_range(0, 30));
            queue_item(KIND_ATTACH, interval, delay);
        end
        else
            queue_item(KIND_SPARE, interval, delay);
    endtask

    task automatic wait_drained();
        while (item_backlog.size() != 0 || accepted_cnt != sent_cnt || report_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_tps(input logic [11:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        m_tps = value;
        @(posedge clk);
    endtask

    initial
    begin
        logic [11:0] tps_plan[6];
        int          p;
        int          n;
        tps_plan = '{12'd1000, 12'd7, 12'd0, 12'd1, 12'd4095, 12'd0};
        tps_plan[5] = 12'($urandom_range(2, 60));
        reset_schedule();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed part with a short second so the seconds counter moves quickly.
        write_tps(12'd3);
        queue_item(KIND_SERVICE, 16'h0000, 16'h0000);
        queue_item(KIND_SPARE, 16'hFFFF, 16'hFFFF);
        queue_item(KIND_TICK, 16'hFFFF, 16'hFFFF);
        queue_item(KIND_ATTACH, 16'hFFFF, 16'hFFFF);
        queue_item(KIND_ATTACH, 16'd5, 16'd0);
        queue_item(KIND_ATTACH, 16'd0, 16'd2);
        queue_item(KIND_ATTACH, 16'd1, 16'd1);
        queue_item(KIND_ATTACH, 16'd2, 16'd1);
        queue_item(KIND_ATTACH, 16'd0, 16'd0);
        repeat (5) queue_item(KIND_TICK, 16'h0000, 16'h0000);
        queue_item(KIND_SERVICE, 16'hFFFF, 16'hFFFF);
        queue_item(KIND_TICK, 16'h0000, 16'h0000);
        queue_item(KIND_SERVICE, 16'h0000, 16'h0000);
        queue_item(KIND_SERVICE, 16'h0000, 16'h0000);
        queue_item(KIND_SPARE, 16'h0000, 16'h0000);
        wait_drained();

        for (p = 0; p < 6; p++)
        begin
            write_tps(tps_plan[p]);
            // One whole phase runs with both sides always ready.
            calm = (p == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                queue_random_item();
            wait_drained();
        end
        calm = 1'b0;

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
